// ----- rtl/insulin_activity_bilinear_assert.svh -----
// Assertion macros shared by the insulin activity block.
// Included by files that check their own control logic; no other dependencies.
`ifndef INSULIN_ACTIVITY_BILINEAR_ASSERT_SVH
`define INSULIN_ACTIVITY_BILINEAR_ASSERT_SVH
`ifndef SYNTH
// The antecedent implies the consequent in the same cycle.
`define IAB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iab: same-cycle check failed");
// The antecedent implies the consequent in the next cycle.
`define IAB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iab: next-cycle check failed");
`else
`define IAB_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define IAB_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/iab_pkg.sv -----
// Widths and fixed-point constants of the insulin activity block.
// No dependencies; used by the channel interfaces, the divider and the top level.
package iab_pkg;

    // Field widths.
    localparam int DUR_W  = 7;
    localparam int DOSE_W = 16;
    localparam int MIN_W  = 10;
    localparam int ACT_W  = 27;
    localparam int IOB_W  = 16;

    localparam logic [DUR_W-1:0] DUR_RESET = 7'd30;

    // Internal datapath widths.
    localparam int SQ_W      = 13;
    localparam int PROD_W    = 2 * SQ_W;
    localparam int DD_W      = 2 * DUR_W;
    localparam int PACT_W    = DOSE_W + MIN_W;
    localparam int DEN_ACT_W = 19;
    localparam int UD_W      = 19;
    localparam int POLY_W    = 34;
    localparam int C2_W      = 35;
    localparam int TAIL_W    = 37;
    localparam int ACT_SHIFT = 17;

    // Pipelined divider geometry.
    localparam int DIV_NUM_W  = 50;
    localparam int DIV_DEN_W  = 34;
    localparam int DIV_Q_W    = ACT_W;
    localparam int DIV_REM_W  = DIV_DEN_W + 1 + DIV_Q_W;
    localparam int DIV_STAGES = DIV_Q_W + 2;

    // Activity denominators before and after the peak, as multiples of d^2.
    localparam logic [4:0] K_RISE = 5'd15;
    localparam logic [4:0] K_FALL = 5'd21;

    // Insulin-on-board polynomial coefficients, scaled by one million.
    localparam logic [19:0] IOB_SCALE = 20'd1000000;
    localparam logic [19:0] C_TAIL    = 20'd555560;
    localparam logic [10:0] C_RISE    = 11'd1852;
    localparam logic [10:0] C_SQ      = 11'd1323;
    localparam logic [15:0] C_LIN     = 16'd54233;

endpackage

// ----- rtl/iab_if.sv -----
// Valid/ready channel interfaces for treatment words in and result words out.
// Depends on iab_pkg for the field widths.
interface iab_in_if;
    logic                         valid;
    logic                         ready;
    logic [iab_pkg::DOSE_W-1:0]   dose_milliunits;
    logic [iab_pkg::MIN_W-1:0]    minutes_since_dose;

    modport source (output valid, dose_milliunits, minutes_since_dose, input ready);
    modport sink   (input valid, dose_milliunits, minutes_since_dose, output ready);
endinterface

interface iab_out_if;
    logic                         valid;
    logic                         ready;
    logic [iab_pkg::ACT_W-1:0]    activity_contribution;
    logic [iab_pkg::IOB_W-1:0]    on_board_milliunits;

    modport source (output valid, activity_contribution, on_board_milliunits, input ready);
    modport sink   (input valid, activity_contribution, on_board_milliunits, output ready);
endinterface

// ----- rtl/iab_div.sv -----
// Pipelined restoring divider that rounds half up and saturates the quotient.
// Depends on iab_pkg for its widths and stage count.
module iab_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [iab_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [iab_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_valid,
    output logic [iab_pkg::DIV_Q_W-1:0]   o_quot
);
    import iab_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_REM_W-1:0]  r_rem [DIV_STAGES];
    logic [DIV_DEN_W:0]    r_div [DIV_STAGES];
    logic [DIV_Q_W-1:0]    r_q   [1:LAST];
    logic [LAST:1]         r_sat;

    logic [DIV_REM_W-1:0]  w_shift [DIV_Q_W];
    logic [DIV_Q_W-1:0]    w_ge;

    // Trial subtraction of each stage: one quotient bit, most significant first.
    always_comb begin
        for (int k = 0; k < DIV_Q_W; k++) begin
            w_shift[k] = DIV_REM_W'(r_div[k+1]) << (DIV_Q_W - 1 - k);
            w_ge[k]    = r_rem[k+1] >= w_shift[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Rounding half up: floor((2n + m) / 2m).
            r_rem[0] <= DIV_REM_W'({i_num, 1'b0}) + DIV_REM_W'(i_den);
            r_div[0] <= {i_den, 1'b0};

            // A quotient that would not fit is flagged once and forced to all ones.
            r_rem[1] <= r_rem[0];
            r_div[1] <= r_div[0];
            r_q[1]   <= '0;
            r_sat[1] <= r_rem[0] >= (DIV_REM_W'(r_div[0]) << DIV_Q_W);

            for (int k = 0; k < DIV_Q_W; k++) begin
                r_rem[k+2] <= w_ge[k] ? (r_rem[k+1] - w_shift[k]) : r_rem[k+1];
                r_div[k+2] <= r_div[k+1];
                r_q[k+2]   <= r_q[k+1] | (DIV_Q_W'(w_ge[k]) << (DIV_Q_W - 1 - k));
                r_sat[k+2] <= r_sat[k+1];
            end
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_quot  = r_sat[LAST] ? '1 : r_q[LAST];

endmodule

// ----- rtl/insulin_activity_bilinear.sv -----
// Top level of the bilinear insulin activity and insulin-on-board block.
// Depends on iab_pkg, iab_if.sv, iab_div and insulin_activity_bilinear_assert.svh.
`include "insulin_activity_bilinear_assert.svh"

// Each input word is one treatment: a dose in milliunits and the whole minutes
// since it was given. Each accepted word yields exactly one result word holding
// the insulin activity per minute (milliunits scaled by 2^16) and the insulin
// still on board (milliunits), both rounded half up and saturated. Activity is
// a triangle that peaks at 75 and ends at 180 minutes of scaled time, and time
// is scaled by three hours over the configured action duration. The duration
// register is written through i_cfg_we and i_cfg_wdata, resets to 3.0 hours,
// and must only change while no word is inside the block. A duration of zero,
// or a treatment at or past the end of action, gives zero for both results.
// The block is a 34-stage pipeline followed by an output register: a word
// accepted at the input passes through stages 1 to 5 and the divider stages
// into the output register, where it is presented until it is taken. One
// word can be accepted in every cycle while the skid register is empty. Most
// of the depth lies in the two pipelined restoring dividers, which produce one
// quotient bit per stage. A one-word skid register behind the output lets the
// pipeline keep moving while the output stalls, until a second word reaches
// the end of the pipeline; that word is parked in the skid register and input
// ready falls. Ready rises again right after the waiting output word is taken.
module insulin_activity_bilinear (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [iab_pkg::DUR_W-1:0] i_cfg_wdata,
    iab_in_if.sink                    i_item,
    iab_out_if.source                 o_result
);
    import iab_pkg::*;

    // ------------------------------------------------------------------
    // Configuration and flow control
    // ------------------------------------------------------------------
    logic [DUR_W-1:0] r_dur;
    logic             w_en;
    logic [5:1]       r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= DUR_RESET;
        end else if (i_cfg_we) begin
            r_dur <= i_cfg_wdata;
        end
    end

    // Every stage advances together; only a full skid register stops them.
    logic r_skid_vld;
    assign w_en         = !r_skid_vld;
    assign i_item.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:1], i_item.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: region decode and small operands
    // ------------------------------------------------------------------
    // In minutes, the peak sits at t = 2.5 d and the end at t = 6 d, where d
    // is the duration in tenths of an hour. After the peak, u = 6t - 15d is
    // six times the minutes past the peak, which is the scaled time past the
    // peak multiplied by d/5.
    logic [MIN_W-1:0]  w_t;
    logic [MIN_W-1:0]  w_six_d;
    logic [MIN_W:0]    w_two_t;
    logic [MIN_W:0]    w_five_d;
    logic              w_zero;
    logic              w_pre;
    logic [MIN_W-1:0]  w_x_act;
    logic [SQ_W-1:0]   w_six_t;
    logic [SQ_W-1:0]   w_six_t_d;
    logic [SQ_W-1:0]   w_fifteen_d;
    logic [SQ_W-1:0]   w_u;
    logic [DD_W-1:0]   w_dd;

    assign w_t         = i_item.minutes_since_dose;
    assign w_six_d     = {1'b0, r_dur, 2'b00} + {2'b00, r_dur, 1'b0};
    assign w_two_t     = {w_t, 1'b0};
    assign w_five_d    = {2'b00, r_dur, 2'b00} + {4'b0000, r_dur};
    assign w_zero      = (r_dur == '0) || (w_t >= w_six_d);
    assign w_pre       = w_two_t < w_five_d;
    assign w_x_act     = w_pre ? w_t : (w_six_d - w_t);
    assign w_six_t     = {1'b0, w_t, 2'b00} + {2'b00, w_t, 1'b0};
    assign w_six_t_d   = w_six_t + SQ_W'(r_dur);
    assign w_fifteen_d = {2'b00, r_dur, 4'b0000} - SQ_W'(r_dur);
    assign w_u         = w_six_t - w_fifteen_d;
    assign w_dd        = DD_W'(r_dur) * DD_W'(r_dur);

    logic [DOSE_W-1:0] r_s1_dose;
    logic [DUR_W-1:0]  r_s1_dur;
    logic [DD_W-1:0]   r_s1_dd;
    logic              r_s1_zero;
    logic              r_s1_pre;
    logic [MIN_W-1:0]  r_s1_x;
    logic [SQ_W-1:0]   r_s1_a;
    logic [SQ_W-1:0]   r_s1_b;
    logic [SQ_W-1:0]   r_s1_u;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dose <= i_item.dose_milliunits;
            r_s1_dur  <= r_dur;
            r_s1_dd   <= w_dd;
            r_s1_zero <= w_zero;
            r_s1_pre  <= w_pre;
            r_s1_x    <= w_x_act;
            // The square term is 6t(6t + d) before the peak and u^2 after it.
            r_s1_a    <= w_pre ? w_six_t : w_u;
            r_s1_b    <= w_pre ? w_six_t_d : w_u;
            r_s1_u    <= w_u;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the independent products
    // ------------------------------------------------------------------
    logic [DOSE_W-1:0]    r_s2_dose;
    logic                 r_s2_zero;
    logic                 r_s2_pre;
    logic [PACT_W-1:0]    r_s2_pact;
    logic [DEN_ACT_W-1:0] r_s2_den_act;
    logic [PROD_W-1:0]    r_s2_sq;
    logic [UD_W-1:0]      r_s2_ud;
    logic [POLY_W-1:0]    r_s2_dd1e6;
    logic [POLY_W-1:0]    r_s2_ddc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dose    <= r_s1_dose;
            r_s2_zero    <= r_s1_zero;
            r_s2_pre     <= r_s1_pre;
            r_s2_pact    <= PACT_W'(r_s1_dose) * PACT_W'(r_s1_x);
            r_s2_den_act <= DEN_ACT_W'(r_s1_pre ? K_RISE : K_FALL) * DEN_ACT_W'(r_s1_dd);
            r_s2_sq      <= PROD_W'(r_s1_a) * PROD_W'(r_s1_b);
            r_s2_ud      <= UD_W'(r_s1_u) * UD_W'(r_s1_dur);
            r_s2_dd1e6   <= POLY_W'(r_s1_dd) * POLY_W'(IOB_SCALE);
            r_s2_ddc     <= POLY_W'(r_s1_dd) * POLY_W'(C_TAIL);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: coefficient products of the on-board polynomial
    // ------------------------------------------------------------------
    logic [DOSE_W-1:0]    r_s3_dose;
    logic                 r_s3_zero;
    logic                 r_s3_pre;
    logic [PACT_W-1:0]    r_s3_pact;
    logic [DEN_ACT_W-1:0] r_s3_den_act;
    logic [POLY_W-1:0]    r_s3_dd1e6;
    logic [POLY_W-1:0]    r_s3_ddc;
    logic [POLY_W-1:0]    r_s3_c1;
    logic [C2_W-1:0]      r_s3_c2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_dose    <= r_s2_dose;
            r_s3_zero    <= r_s2_zero;
            r_s3_pre     <= r_s2_pre;
            r_s3_pact    <= r_s2_pact;
            r_s3_den_act <= r_s2_den_act;
            r_s3_dd1e6   <= r_s2_dd1e6;
            r_s3_ddc     <= r_s2_ddc;
            r_s3_c1      <= POLY_W'(r_s2_pre ? C_RISE : C_SQ) * POLY_W'(r_s2_sq);
            r_s3_c2      <= C2_W'(C_LIN) * C2_W'(r_s2_ud);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: polynomial sum, clamped at zero
    // ------------------------------------------------------------------
    // The falling-side quadratic dips slightly below zero just before the
    // end of action; the sign bit of the wide sum catches that.
    logic [TAIL_W-1:0] w_tail;
    logic [POLY_W-1:0] w_poly;

    assign w_tail = TAIL_W'(r_s3_c1) + TAIL_W'(r_s3_ddc) - TAIL_W'(r_s3_c2);
    assign w_poly = r_s3_pre          ? (r_s3_dd1e6 - r_s3_c1) :
                    w_tail[TAIL_W-1]  ? '0 : w_tail[POLY_W-1:0];

    logic [DOSE_W-1:0]    r_s4_dose;
    logic                 r_s4_zero;
    logic [PACT_W-1:0]    r_s4_pact;
    logic [DEN_ACT_W-1:0] r_s4_den_act;
    logic [POLY_W-1:0]    r_s4_den_iob;
    logic [POLY_W-1:0]    r_s4_poly;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_dose    <= r_s3_dose;
            r_s4_zero    <= r_s3_zero;
            r_s4_pact    <= r_s3_pact;
            r_s4_den_act <= r_s3_den_act;
            r_s4_den_iob <= r_s3_dd1e6;
            r_s4_poly    <= w_poly;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divider operands
    // ------------------------------------------------------------------
    // Outside the curve the numerator is zero and the divisor one, so both
    // dividers return zero and never see a zero divisor.
    logic [DIV_NUM_W-1:0] r_s5_num_act;
    logic [DIV_DEN_W-1:0] r_s5_den_act;
    logic [DIV_NUM_W-1:0] r_s5_num_iob;
    logic [DIV_DEN_W-1:0] r_s5_den_iob;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_num_act <= r_s4_zero ? '0 : (DIV_NUM_W'(r_s4_pact) << ACT_SHIFT);
            r_s5_den_act <= r_s4_zero ? DIV_DEN_W'(1) : DIV_DEN_W'(r_s4_den_act);
            r_s5_num_iob <= r_s4_zero ? '0 : DIV_NUM_W'(r_s4_dose) * DIV_NUM_W'(r_s4_poly);
            r_s5_den_iob <= r_s4_zero ? DIV_DEN_W'(1) : DIV_DEN_W'(r_s4_den_iob);
        end
    end

    // ------------------------------------------------------------------
    // Dividers
    // ------------------------------------------------------------------
    logic                 w_act_vld;
    logic                 w_iob_vld;
    logic [ACT_W-1:0]     w_act_q;
    logic [DIV_Q_W-1:0]   w_iob_q;
    logic [IOB_W-1:0]     w_iob_sat;

    iab_div u_div_act (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[5]),
        .i_num   (r_s5_num_act),
        .i_den   (r_s5_den_act),
        .o_valid (w_act_vld),
        .o_quot  (w_act_q)
    );

    iab_div u_div_iob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[5]),
        .i_num   (r_s5_num_iob),
        .i_den   (r_s5_den_iob),
        .o_valid (w_iob_vld),
        .o_quot  (w_iob_q)
    );

    assign w_iob_sat = (|w_iob_q[DIV_Q_W-1:IOB_W]) ? '1 : w_iob_q[IOB_W-1:0];

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic [ACT_W-1:0]  r_out_act;
    logic [IOB_W-1:0]  r_out_iob;
    logic [ACT_W-1:0]  r_skid_act;
    logic [IOB_W-1:0]  r_skid_iob;
    logic              w_take;

    assign w_take = r_out_vld && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= w_act_vld;
            end else if (w_act_vld) begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_out_vld || w_take) begin
                r_out_act <= w_act_q;
                r_out_iob <= w_iob_sat;
            end else begin
                r_skid_act <= w_act_q;
                r_skid_iob <= w_iob_sat;
            end
        end else if (w_take) begin
            r_out_act <= r_skid_act;
            r_out_iob <= r_skid_iob;
        end
    end

    assign o_result.valid                 = r_out_vld;
    assign o_result.activity_contribution = r_out_act;
    assign o_result.on_board_milliunits   = r_out_iob;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // The skid register only fills behind a waiting output word.
    `IAB_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // Both dividers advance in lockstep, so their words line up.
    `IAB_ASSERT_IMPL(a_div_lockstep, i_clk, i_rst_n,
                     w_act_vld || w_iob_vld, w_act_vld == w_iob_vld)
    // A word leaving the pipeline while the output stalls is parked, not lost.
    `IAB_ASSERT_NEXT(a_park_in_skid, i_clk, i_rst_n,
                     w_en && w_act_vld && r_out_vld && !o_result.ready, r_skid_vld)
    // A parked word stays parked until the output is taken.
    `IAB_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n,
                     r_skid_vld && !o_result.ready, r_skid_vld && r_out_vld)

endmodule
